// ===== src/sefd_pkg.sv =====
`timescale 1ns / 1ps

package sefd_pkg;

    localparam int MAX_PAYLOAD = 256;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int COUNT_W = 9;
    localparam int KIND_W  = 2;

    localparam logic [BYTE_W-1:0] STX_BYTE  = 8'hAA;
    localparam logic [BYTE_W-1:0] ETX_BYTE  = 8'h55;
    localparam logic [LEN_W-1:0]  LEN_LIMIT = LEN_W'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_OPCODE  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5,
        PH_ETX     = 3'd6
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TENTATIVE = 2'd0,
        KIND_COMMIT    = 2'd1,
        KIND_DROP      = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   data;
        logic [BYTE_W-1:0]   opcode;
        logic [COUNT_W-1:0]  position;
    } result_t;

endpackage

// ===== src/sefd_parser.sv =====
`timescale 1ns / 1ps

module sefd_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_accept,
    input  logic [sefd_pkg::BYTE_W-1:0] rx_byte,
    output logic                        res_valid,
    output sefd_pkg::result_t           res
);

    sefd_pkg::phase_t                   phase_reg, phase_next;
    logic [sefd_pkg::LEN_W-1:0]         length_reg, length_next;
    logic [sefd_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [sefd_pkg::BYTE_W-1:0]        opcode_reg, opcode_next;
    logic [sefd_pkg::BYTE_W-1:0]        crc_reg, crc_next;
    logic [sefd_pkg::LEN_W-1:0]         length_full;
    logic [sefd_pkg::COUNT_W-1:0]       count_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= sefd_pkg::PH_HUNT;
            length_reg <= '0;
            count_reg  <= '0;
            opcode_reg <= '0;
            crc_reg    <= '0;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            opcode_reg <= opcode_next;
            crc_reg    <= crc_next;
        end
    end

    assign length_full = {length_reg[sefd_pkg::LEN_W-1:sefd_pkg::BYTE_W], rx_byte};
    assign count_inc   = count_reg + 1'b1;

    always_comb begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        opcode_next  = opcode_reg;
        crc_next     = crc_reg;
        res_valid    = 1'b0;
        res.kind     = sefd_pkg::KIND_DROP;
        res.data     = '0;
        res.opcode   = '0;
        res.position = '0;
        case (phase_reg)
            sefd_pkg::PH_HUNT: begin
                if (rx_byte == sefd_pkg::STX_BYTE) begin
                    phase_next = sefd_pkg::PH_LEN_HI;
                    count_next = '0;
                end
            end
            sefd_pkg::PH_LEN_HI: begin
                length_next = {rx_byte, {sefd_pkg::BYTE_W{1'b0}}};
                phase_next  = sefd_pkg::PH_LEN_LO;
            end
            sefd_pkg::PH_LEN_LO: begin
                length_next = length_full;
                opcode_next = '0;
                crc_next    = '0;
                if (length_full > sefd_pkg::LEN_LIMIT) begin
                    phase_next = sefd_pkg::PH_HUNT;
                    res_valid  = 1'b1;
                end else begin
                    phase_next = sefd_pkg::PH_OPCODE;
                end
            end
            sefd_pkg::PH_OPCODE: begin
                opcode_next = rx_byte;
                count_next  = '0;
                phase_next  = (length_reg == '0) ? sefd_pkg::PH_CRC : sefd_pkg::PH_PAYLOAD;
            end
            sefd_pkg::PH_PAYLOAD: begin
                count_next = count_inc;
                if (sefd_pkg::LEN_W'(count_inc) >= length_reg) begin
                    phase_next = sefd_pkg::PH_CRC;
                end
                res_valid    = 1'b1;
                res.kind     = sefd_pkg::KIND_TENTATIVE;
                res.data     = rx_byte;
                res.opcode   = opcode_reg;
                res.position = count_reg;
            end
            sefd_pkg::PH_CRC: begin
                crc_next   = rx_byte;
                phase_next = sefd_pkg::PH_ETX;
            end
            sefd_pkg::PH_ETX: begin
                phase_next   = sefd_pkg::PH_HUNT;
                res_valid    = 1'b1;
                res.opcode   = opcode_reg;
                res.position = count_reg;
                if (rx_byte == sefd_pkg::ETX_BYTE) begin
                    res.kind = sefd_pkg::KIND_COMMIT;
                    res.data = crc_reg;
                end
            end
            default: begin
                phase_next = sefd_pkg::PH_HUNT;
            end
        endcase
    end

endmodule

// ===== src/stx_etx_frame_deframer.sv =====
`timescale 1ns / 1ps
// Each accepted byte updates the parser in the cycle it is taken, and any result
// appears on the m_ side in the following cycle from the output register.
// Throughput is one byte per cycle; a new byte is taken whenever the output
// register is empty or its transaction completes in the same cycle.
// Synchronous active-low reset returns the parser to hunting for STX and empties the output.

module stx_etx_frame_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sefd_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sefd_pkg::KIND_W-1:0]   m_result_kind,
    output logic [sefd_pkg::BYTE_W-1:0]   m_data_byte,
    output logic [sefd_pkg::BYTE_W-1:0]   m_opcode,
    output logic [sefd_pkg::COUNT_W-1:0]  m_position
);

    logic              in_accept;
    logic              res_valid;
    sefd_pkg::result_t res;
    logic              out_valid_reg, out_valid_next;
    sefd_pkg::result_t out_reg;

    assign s_ready   = !out_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    sefd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .rx_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (in_accept) begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_reg.kind;
    assign m_data_byte   = out_reg.data;
    assign m_opcode      = out_reg.opcode;
    assign m_position    = out_reg.position;

endmodule
